// ===== src/chh_pkg.sv =====
// Shared types, constants and helper functions of the character class histogram.
package chh_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_W     = 32;
    localparam int EXT_W       = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam int BIN_COUNT   = 62;
    localparam int BIN_AW      = $clog2(BIN_COUNT);

    localparam int UPPER_BASE  = 0;
    localparam int LOWER_BASE  = 26;
    localparam int DIGIT_BASE  = 52;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    localparam logic FUNC_COUNT  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_AW-1:0]      bin_addr_t;

    localparam count_t LINE_RESET = COUNT_WIDTH'(1);

    typedef enum logic [1:0] {
        KIND_BIN    = 2'd0,
        KIND_LINES  = 2'd1,
        KIND_BLANKS = 2'd2
    } kind_t;

    // Read request from the sequencer to the bin unit
    typedef struct packed {
        logic      req;
        logic      walk;
        bin_addr_t addr;
    } bin_req_t;

    // Nonzero bin found during a report walk
    typedef struct packed {
        logic      valid;
        bin_addr_t addr;
        count_t    value;
    } bin_emit_t;

    typedef struct packed {
        logic      is_bin;
        logic      is_newline;
        logic      is_space;
        bin_addr_t bin;
    } char_class_t;

    // Sort one byte into newline, space, a letter or digit bin, or nothing
    function automatic char_class_t classify(logic [7:0] ch);
        char_class_t c;
        c = '0;
        if (ch == CH_NEWLINE) begin
            c.is_newline = 1'b1;
        end else if (ch == CH_SPACE) begin
            c.is_space = 1'b1;
        end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            c.is_bin = 1'b1;
            c.bin    = BIN_AW'((ch - CH_UPPER_A) + 8'(UPPER_BASE));
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            c.is_bin = 1'b1;
            c.bin    = BIN_AW'((ch - CH_LOWER_A) + 8'(LOWER_BASE));
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            c.is_bin = 1'b1;
            c.bin    = BIN_AW'((ch - CH_DIGIT_0) + 8'(DIGIT_BASE));
        end
        return c;
    endfunction

    // Map a bin index back to its character code
    function automatic logic [7:0] bin_symbol(bin_addr_t b);
        logic [7:0] s;
        if (8'(b) < 8'(LOWER_BASE)) begin
            s = CH_UPPER_A + (8'(b) - 8'(UPPER_BASE));
        end else if (8'(b) < 8'(DIGIT_BASE)) begin
            s = CH_LOWER_A + (8'(b) - 8'(LOWER_BASE));
        end else begin
            s = CH_DIGIT_0 + (8'(b) - 8'(DIGIT_BASE));
        end
        return s;
    endfunction

    // Increment, holding at full scale
    function automatic count_t sat_inc(count_t v);
        count_t r;
        r = (v == '1) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

    // Clamp a counter to the width of the total port
    function automatic logic [TOTAL_W-1:0] show_total(count_t v);
        logic [EXT_W-1:0] e;
        logic [TOTAL_W-1:0] r;
        e = EXT_W'(v);
        if (e > EXT_W'({TOTAL_W{1'b1}})) begin
            r = '1;
        end else begin
            r = e[TOTAL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/character_class_histogram_top.sv =====
// Character class histogram: top level with the report sequencer and output word register.
//
// Usage: present a word on func/char_code with start high; it is taken at the
// rising edge where start is high and busy is low.
// func = 0 counts one byte. Letters and digits go to 62 bins kept in a RAM
// (registered read, then modify and write, with forwarding of the last write), so
// busy stays low and one byte is taken every cycle. Newline and space go to
// two saturating registers; other bytes change nothing. No result word.
// func = 1 starts a report and raises busy: the walk reads the
// bin RAM one address per cycle, then a flush state drains the read stage, then
// the line total and the blank total go out. Each nonzero bin gives one
// result word (strobe high for one cycle), in bin order; then the line total,
// and the blank total last with last high, in the first cycle with
// busy low. The report then leaves bins and blanks at zero and lines at one.
// The receiver cannot stall: every strobe cycle is taken.
// Reset: the bin valid bits clear at once, so no clearing pass is needed;
// the block takes a word in the first cycle after reset.
module character_class_histogram_top
    import chh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic [7:0]         char_code,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic [7:0]         symbol,
    output logic [TOTAL_W-1:0] total,
    output logic               last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_LINES,
        ST_BLANKS
    } state_t;

    state_t             state_reg;
    bin_addr_t          walk_idx_reg;
    count_t             line_reg;
    count_t             blank_reg;
    logic               strobe_reg;
    kind_t              kind_reg;
    logic [7:0]         symbol_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               last_reg;

    logic               accept;
    char_class_t        cls;
    bin_req_t           req;
    bin_emit_t          emit;
    logic               clear_all;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cls       = classify(char_code);
    assign clear_all = (state_reg == ST_BLANKS);

    // Issue a bin read: a counted letter or digit, or the next walk address
    always_comb
    begin
        req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.req  = accept && (func == FUNC_COUNT) && cls.is_bin;
                req.walk = 1'b0;
                req.addr = cls.bin;
            end
            ST_WALK:
            begin
                req.req  = 1'b1;
                req.walk = 1'b1;
                req.addr = walk_idx_reg;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    chh_bin_unit u_bin_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .clear_all (clear_all),
        .emit      (emit)
    );

    // Sequence reports, keep line and blank totals, register the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            walk_idx_reg <= '0;
            line_reg     <= LINE_RESET;
            blank_reg    <= '0;
            strobe_reg   <= 1'b0;
            kind_reg     <= KIND_BIN;
            symbol_reg   <= '0;
            total_reg    <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            // Load the result word: a nonzero bin, then the two totals
            if (emit.valid)
            begin
                strobe_reg <= 1'b1;
                kind_reg   <= KIND_BIN;
                symbol_reg <= bin_symbol(emit.addr);
                total_reg  <= show_total(emit.value);
                last_reg   <= 1'b0;
            end
            else if (state_reg == ST_LINES)
            begin
                strobe_reg <= 1'b1;
                kind_reg   <= KIND_LINES;
                symbol_reg <= '0;
                total_reg  <= show_total(line_reg);
                last_reg   <= 1'b0;
            end
            else if (state_reg == ST_BLANKS)
            begin
                strobe_reg <= 1'b1;
                kind_reg   <= KIND_BLANKS;
                symbol_reg <= '0;
                total_reg  <= show_total(blank_reg);
                last_reg   <= 1'b1;
            end
            else
            begin
                strobe_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (func == FUNC_REPORT)
                        begin
                            state_reg    <= ST_WALK;
                            walk_idx_reg <= '0;
                        end
                        else if (cls.is_newline)
                        begin
                            line_reg <= sat_inc(line_reg);
                        end
                        else if (cls.is_space)
                        begin
                            blank_reg <= sat_inc(blank_reg);
                        end
                    end
                end
                ST_WALK:
                begin
                    if (walk_idx_reg == BIN_AW'(BIN_COUNT - 1))
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        walk_idx_reg <= walk_idx_reg + BIN_AW'(1);
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_LINES;
                end
                ST_LINES:
                begin
                    state_reg <= ST_BLANKS;
                end
                ST_BLANKS:
                begin
                    line_reg  <= LINE_RESET;
                    blank_reg <= '0;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign kind   = kind_reg;
    assign symbol = symbol_reg;
    assign total  = total_reg;
    assign last   = last_reg;

endmodule

// ===== src/chh_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module chh_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/chh_bin_unit.sv =====
// Bin counter store: RAM read-modify-write with forwarding and per-bin valid bits.
module chh_bin_unit
    import chh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bin_req_t  req,
    input  logic      clear_all,
    output bin_emit_t emit
);

    logic                 s2_valid_reg;
    logic                 s2_walk_reg;
    bin_addr_t            s2_addr_reg;
    logic                 fwd_valid_reg;
    bin_addr_t            fwd_addr_reg;
    count_t               fwd_data_reg;
    logic [BIN_COUNT-1:0] bin_valid_reg;

    count_t               rd_data;
    count_t               cur;
    logic                 wr_en;
    count_t               wr_data;

    chh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_addr_reg),
        .wdata (wr_data),
        .re    (req.req),
        .raddr (req.addr),
        .rdata (rd_data)
    );

    // Pick the current bin value: the write that landed with our read, else RAM if the bin was written, else zero
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == s2_addr_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (bin_valid_reg[s2_addr_reg])
        begin
            cur = rd_data;
        end
        else
        begin
            cur = '0;
        end
    end

    assign wr_en   = s2_valid_reg && !s2_walk_reg;
    assign wr_data = sat_inc(cur);

    assign emit.valid = s2_valid_reg && s2_walk_reg && (cur != '0);
    assign emit.addr  = s2_addr_reg;
    assign emit.value = cur;

    // Advance the read stage, track the last write and the written bins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s2_walk_reg   <= 1'b0;
            s2_addr_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
            fwd_data_reg  <= '0;
            bin_valid_reg <= '0;
        end
        else
        begin
            s2_valid_reg  <= req.req;
            s2_walk_reg   <= req.walk;
            s2_addr_reg   <= req.addr;
            fwd_valid_reg <= wr_en;
            fwd_addr_reg  <= s2_addr_reg;
            fwd_data_reg  <= wr_data;
            if (clear_all)
            begin
                bin_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                bin_valid_reg[s2_addr_reg] <= 1'b1;
            end
        end
    end

endmodule

// ===== src/chh_checker.sv =====
// Port-level checker for the character class histogram, bound to the top level.
module chh_checker
    import chh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               func,
    input logic               strobe,
    input logic [1:0]         kind,
    input logic [TOTAL_W-1:0] total,
    input logic               last
);

    // The final word of a report stands alone
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("word follows the last word of a report");

    // Every word but the last comes while the report holds the block busy
    a_busy_during_report: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("report word outside a busy report");

    // Line total is followed at once by the blank total, which closes the report
    a_lines_then_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_LINES |=> strobe && kind == KIND_BLANKS && last)
        else $error("line total not followed by closing blank total");

    // A taken report request makes the block busy
    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FUNC_REPORT |=> busy)
        else $error("report request did not raise busy");

    // Bin words carry a nonzero count and never close the report
    a_bin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_BIN |-> total != '0 && !last)
        else $error("bin word with zero count or last set");

endmodule

bind character_class_histogram_top chh_checker u_chh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .strobe (strobe),
    .kind   (kind),
    .total  (total),
    .last   (last)
);

// ===== verif/tb.sv =====
// Self-checking testbench of the character class histogram: queued driver, checking monitor.
module tb;
    import chh_pkg::*;

    // One word for the block, with the gap odds of its phase and a drain mark
    typedef struct packed {
        logic       func;
        logic [7:0] code;
        logic [6:0] gap_pct;
        logic       drain;
    } text_word_t;

    // One expected report word
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         symbol;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } hist_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    logic               func = FUNC_COUNT;
    logic [7:0]         char_code = 8'h00;
    logic               strobe;
    logic [1:0]         kind;
    logic [7:0]         symbol;
    logic [TOTAL_W-1:0] total;
    logic               last;

    text_word_t   word_q [$];
    hist_result_t report_q [$];
    text_word_t   next_word;

    // Predicted counters of the block
    count_t bin_tally [BIN_COUNT];
    count_t line_tally;
    count_t blank_tally;

    logic drained;
    logic drain_armed = 1'b0;
    int   err_count = 0;
    int   cur_gap = 0;
    logic next_drain = 1'b0;

    character_class_histogram_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .char_code (char_code),
        .strobe    (strobe),
        .kind      (kind),
        .symbol    (symbol),
        .total     (total),
        .last      (last)
    );

    always #6 clk = ~clk;

    task automatic flag_mismatch(string msg);
        $display("tb: mismatch: %s", msg);
        err_count++;
    endtask

    // Character code held by a bin index
    function automatic logic [7:0] glyph_of(int idx);
        logic [7:0] g;
        if (idx < LOWER_BASE)
        begin
            g = CH_UPPER_A + 8'(idx - UPPER_BASE);
        end
        else if (idx < DIGIT_BASE)
        begin
            g = CH_LOWER_A + 8'(idx - LOWER_BASE);
        end
        else
        begin
            g = CH_DIGIT_0 + 8'(idx - DIGIT_BASE);
        end
        return g;
    endfunction

    // Add one, stopping at full scale
    function automatic count_t bump(count_t v);
        count_t r;
        if (v == {COUNT_WIDTH{1'b1}})
        begin
            r = v;
        end
        else
        begin
            r = v + count_t'(1);
        end
        return r;
    endfunction

    // Clamp a counter to what the total port can show
    function automatic logic [TOTAL_W-1:0] clamp_total(count_t v);
        logic [63:0]        wide;
        logic [TOTAL_W-1:0] r;
        wide = 64'(v);
        if (wide > 64'({TOTAL_W{1'b1}}))
        begin
            r = '1;
        end
        else
        begin
            r = wide[TOTAL_W-1:0];
        end
        return r;
    endfunction

    task automatic clear_tally();
        for (int i = 0; i < BIN_COUNT; i++)
        begin
            bin_tally[i] = '0;
        end
        line_tally  = count_t'(1);
        blank_tally = '0;
    endtask

    // Advance the predicted counters by one taken word; queue the report it causes
    task automatic tally_word(logic f, logic [7:0] ch);
        hist_result_t r;
        int           idx;
        idx = -1;
        if (f == FUNC_REPORT)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                if (bin_tally[i] != '0)
                begin
                    r = '{KIND_BIN, glyph_of(i), clamp_total(bin_tally[i]), 1'b0};
                    report_q.push_back(r);
                end
            end
            r = '{KIND_LINES, 8'h00, clamp_total(line_tally), 1'b0};
            report_q.push_back(r);
            r = '{KIND_BLANKS, 8'h00, clamp_total(blank_tally), 1'b1};
            report_q.push_back(r);
            clear_tally();
        end
        else if (ch == CH_NEWLINE)
        begin
            line_tally = bump(line_tally);
        end
        else if (ch == CH_SPACE)
        begin
            blank_tally = bump(blank_tally);
        end
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            idx = UPPER_BASE + int'(ch - CH_UPPER_A);
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            idx = LOWER_BASE + int'(ch - CH_LOWER_A);
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            idx = DIGIT_BASE + int'(ch - CH_DIGIT_0);
        end
        if (idx >= 0)
        begin
            bin_tally[idx] = bump(bin_tally[idx]);
        end
    endtask

    // Compare one result word with the oldest expectation
    task automatic check_result();
        hist_result_t want;
        if (report_q.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected word kind %0d symbol %02h total %0d last %0b",
                                    kind, symbol, total, last));
        end
        else
        begin
            want = report_q.pop_front();
            if (kind !== want.kind)
                flag_mismatch($sformatf("kind %0d, want %0d (symbol %02h)",
                                        kind, want.kind, want.symbol));
            if (symbol !== want.symbol)
                flag_mismatch($sformatf("symbol %02h, want %02h", symbol, want.symbol));
            if (total !== want.total)
                flag_mismatch($sformatf("total %0d, want %0d (kind %0d symbol %02h)",
                                        total, want.total, want.kind, want.symbol));
            if (last !== want.last)
                flag_mismatch($sformatf("last %0b, want %0b (kind %0d symbol %02h)",
                                        last, want.last, want.kind, want.symbol));
        end
    endtask

    // Driver: hold a word until taken, then present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            func        <= FUNC_COUNT;
            char_code   <= 8'h00;
            drain_armed <= 1'b0;
        end
        else
        begin
            if (start && busy)
            begin
                // hold
            end
            else if (word_q.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (word_q[0].drain && !drain_armed)
            begin
                start       <= 1'b0;
                drain_armed <= 1'b1;
            end
            else if (word_q[0].drain && !drained)
            begin
                start <= 1'b0;
            end
            else if ($urandom_range(0, 99) < word_q[0].gap_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                next_word   = word_q.pop_front();
                start       <= 1'b1;
                func        <= next_word.func;
                char_code   <= next_word.code;
                drain_armed <= 1'b0;
            end
        end
    end

    // Monitor: check result words, predict from taken words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tally();
            drained <= 1'b1;
        end
        else
        begin
            if (strobe === 1'b1)
                check_result();
            if (start && busy === 1'b0)
                tally_word(func, char_code);
            drained <= (report_q.size() == 0);
        end
    end

    task automatic add_word(logic f, logic [7:0] ch);
        text_word_t w;
        w = '{f, ch, 7'(cur_gap), next_drain};
        next_drain = 1'b0;
        word_q.push_back(w);
    endtask

    // Mostly letters and digits, with newline and space
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 63);
        if (r < BIN_COUNT)
            return glyph_of(r);
        else if (r == BIN_COUNT)
            return CH_NEWLINE;
        return CH_SPACE;
    endfunction

    // Stimulus and end of run
    initial
    begin
        int burst;
        int len;
        int settle;
        rst_n = 1'b0;

        // directed: empty report, class edges, ignored bytes, back-to-back reports
        cur_gap = 0;
        add_word(FUNC_REPORT, 8'h00);
        add_word(FUNC_COUNT, CH_UPPER_A);
        add_word(FUNC_COUNT, CH_UPPER_Z);
        add_word(FUNC_COUNT, CH_LOWER_A);
        add_word(FUNC_COUNT, CH_LOWER_Z);
        add_word(FUNC_COUNT, CH_DIGIT_0);
        add_word(FUNC_COUNT, CH_DIGIT_9);
        add_word(FUNC_COUNT, CH_NEWLINE);
        add_word(FUNC_COUNT, CH_SPACE);
        add_word(FUNC_COUNT, 8'h00);
        add_word(FUNC_COUNT, 8'hFF);
        add_word(FUNC_COUNT, 8'h40);
        add_word(FUNC_COUNT, 8'h5B);
        add_word(FUNC_COUNT, 8'h60);
        add_word(FUNC_COUNT, 8'h7B);
        add_word(FUNC_COUNT, 8'h2F);
        add_word(FUNC_COUNT, 8'h3A);
        add_word(FUNC_COUNT, 8'h80);
        add_word(FUNC_COUNT, CH_UPPER_A);
        add_word(FUNC_COUNT, CH_NEWLINE);
        add_word(FUNC_COUNT, CH_SPACE);
        add_word(FUNC_REPORT, 8'hFF);
        next_drain = 1'b1;
        add_word(FUNC_REPORT, CH_UPPER_Z);

        // random: text bursts closed by a report, some noise, one full alphabet
        burst = 0;
        while (word_q.size() < 262)
        begin
            case ((burst / 3) % 4)
                0: cur_gap = 0;
                1: cur_gap = 75;
                2: cur_gap = 0;
                default: cur_gap = 20;
            endcase
            if (burst == 5)
            begin
                for (int i = BIN_COUNT - 1; i >= 0; i--)
                    add_word(FUNC_COUNT, glyph_of(i));
                add_word(FUNC_REPORT, 8'(32'($urandom_range(0, 255))));
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_word(FUNC_REPORT, 8'(32'($urandom_range(0, 255))));
                    else
                        add_word(FUNC_COUNT, 8'(32'($urandom_range(0, 255))));
                end
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    next_drain = 1'b1;
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        add_word(FUNC_COUNT, 8'(32'($urandom_range(0, 255))));
                    else
                        add_word(FUNC_COUNT, pick_text_byte());
                end
                add_word(FUNC_REPORT, 8'(32'($urandom_range(0, 255))));
            end
            burst++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last word to be taken, then for the results to drain
        @(negedge clk);
        while (word_q.size() != 0 || start)
            @(negedge clk);
        settle = 0;
        while (report_q.size() != 0 && settle < 2000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (80) @(negedge clk);
        if (report_q.size() != 0)
            flag_mismatch($sformatf("%0d expected words never came", report_q.size()));
        if (err_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(12 * 400000);
        $display("tb: done, errors");
        $finish;
    end

endmodule
